// File: rtl/core/qmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_pkg
// Shared types and constants of the queue with middle insertion.
// ----------------------------------------------------------------------------
package qmi_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int OCC_W          = 11;
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take a request and launch both memory reads
    logic commit;  // write back, update pointers and load the result register
  } ctrl_cmd_t;

endpackage

// File: rtl/core/qmi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_ctrl
// Controller: sequences a request through read and write-back, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module qmi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qmi_pkg::ctrl_cmd_t cmd_o
);

  qmi_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qmi_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      qmi_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = qmi_pkg::S_EXEC;
        end
      end
      qmi_pkg::S_EXEC: begin
        // The result register must be free or emptying before we commit.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = qmi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = qmi_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/qmi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_dp
// Datapath: the two circular half stores, their head and count registers,
// the request registers and the result register.
// ----------------------------------------------------------------------------
module qmi_dp #(
  parameter int CAPACITY   = qmi_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = qmi_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qmi_pkg::ctrl_cmd_t            cmd_i,
  input  logic [qmi_pkg::OP_W-1:0]      op_i,
  input  logic [qmi_pkg::VALUE_W-1:0]   value_i,
  output logic [qmi_pkg::VALUE_W-1:0]   popped_o,
  output logic [qmi_pkg::STATUS_W-1:0]  status_o,
  output logic [qmi_pkg::OCC_W-1:0]     occ_o
);

  localparam int HALF  = (CAPACITY + 1) / 2;
  localparam int IDX_W = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int CNT_W = $clog2(HALF + 1);
  localparam int TOT_W = CNT_W + 1;
  localparam int VW    = qmi_pkg::VALUE_W;
  localparam int OW    = qmi_pkg::OCC_W;

  localparam logic [CNT_W:0]   HALF_S   = (CNT_W + 1)'(HALF);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HALF - 1);
  localparam logic [TOT_W-1:0] CAP_S    = TOT_W'(CAPACITY);

  logic [DATA_WIDTH-1:0] front_mem [HALF];
  logic [DATA_WIDTH-1:0] back_mem  [HALF];

  logic [IDX_W-1:0] fh_q, fh_d, bh_q, bh_d;
  logic [CNT_W-1:0] fc_q, fc_d, bc_q, bc_d;

  qmi_pkg::op_e          op_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] rd_front_q, rd_back_q;

  logic [VW-1:0]                  popped_q, popped_d;
  logic [qmi_pkg::STATUS_W-1:0]   status_q;
  qmi_pkg::status_e               status_d;
  logic [OW-1:0]                  occ_q, occ_d;

  logic [DATA_WIDTH+VW-1:0] val_ext;
  logic [DATA_WIDTH+VW-1:0] pop_ext;
  logic [CNT_W:0]           ftail_sum, btail_sum;
  logic [IDX_W-1:0]         ftail, btail, fh_next, bh_next, bh_prev;
  logic [TOT_W-1:0]         tot, tot_new;
  logic [TOT_W+OW-1:0]      occ_ext;
  logic                     even, full, fempty;

  logic                  fwe, bwe;
  logic [IDX_W-1:0]      fwaddr, bwaddr;
  logic [DATA_WIDTH-1:0] fwdata, bwdata;

  // Stored values keep the low bits of the sign-extended input.
  assign val_ext = {{DATA_WIDTH{value_i[VW-1]}}, value_i};
  assign pop_ext = {{VW{rd_front_q[DATA_WIDTH-1]}}, rd_front_q};

  always_comb begin
    ftail_sum = (CNT_W + 1)'(fh_q) + (CNT_W + 1)'(fc_q);
    if (ftail_sum >= HALF_S) begin
      ftail_sum = ftail_sum - HALF_S;
    end
    btail_sum = (CNT_W + 1)'(bh_q) + (CNT_W + 1)'(bc_q);
    if (btail_sum >= HALF_S) begin
      btail_sum = btail_sum - HALF_S;
    end
    ftail   = ftail_sum[IDX_W-1:0];
    btail   = btail_sum[IDX_W-1:0];
    fh_next = (fh_q == LAST_IDX) ? '0 : fh_q + IDX_W'(1);
    bh_next = (bh_q == LAST_IDX) ? '0 : bh_q + IDX_W'(1);
    bh_prev = (bh_q == '0) ? LAST_IDX : bh_q - IDX_W'(1);
    tot     = TOT_W'(fc_q) + TOT_W'(bc_q);
    even    = (fc_q == bc_q);
    full    = (tot >= CAP_S);
    fempty  = (fc_q == '0);
  end

  always_comb begin
    fh_d     = fh_q;
    bh_d     = bh_q;
    fc_d     = fc_q;
    bc_d     = bc_q;
    fwe      = 1'b0;
    bwe      = 1'b0;
    fwaddr   = ftail;
    bwaddr   = btail;
    fwdata   = val_q;
    bwdata   = val_q;
    popped_d = '0;
    status_d = qmi_pkg::STATUS_DONE;
    case (op_q)
      qmi_pkg::OP_PUSH: begin
        if (full) begin
          status_d = qmi_pkg::STATUS_FULL;
        end else begin
          bwe = 1'b1;
          if (even) begin
            // The back head moves over to the front; an empty back half
            // hands the new value straight through.
            fwe    = 1'b1;
            fwdata = (bc_q == '0) ? val_q : rd_back_q;
            bh_d   = bh_next;
            fc_d   = fc_q + CNT_W'(1);
          end else begin
            bc_d = bc_q + CNT_W'(1);
          end
        end
      end
      qmi_pkg::OP_INSERT: begin
        if (full) begin
          status_d = qmi_pkg::STATUS_FULL;
        end else if (even) begin
          fwe  = 1'b1;
          fc_d = fc_q + CNT_W'(1);
        end else begin
          bwe    = 1'b1;
          bwaddr = bh_prev;
          bh_d   = bh_prev;
          bc_d   = bc_q + CNT_W'(1);
        end
      end
      qmi_pkg::OP_POP: begin
        if (fempty) begin
          status_d = qmi_pkg::STATUS_EMPTY;
        end else begin
          popped_d = pop_ext[VW-1:0];
          fh_d     = fh_next;
          if (even) begin
            // Refill the front from the back head; the front count holds.
            fwe    = 1'b1;
            fwdata = rd_back_q;
            bh_d   = bh_next;
            bc_d   = bc_q - CNT_W'(1);
          end else begin
            fc_d = fc_q - CNT_W'(1);
          end
        end
      end
      default: begin
        status_d = qmi_pkg::STATUS_DONE;
      end
    endcase
    tot_new = TOT_W'(fc_d) + TOT_W'(bc_d);
    occ_ext = (TOT_W + OW)'(tot_new);
    occ_d   = occ_ext[OW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q <= '0;
      bh_q <= '0;
      fc_q <= '0;
      bc_q <= '0;
    end else if (cmd_i.commit) begin
      fh_q <= fh_d;
      bh_q <= bh_d;
      fc_q <= fc_d;
      bc_q <= bc_d;
    end
  end

  // Request registers and registered memory reads at the current heads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= qmi_pkg::op_e'(op_i);
      val_q      <= val_ext[DATA_WIDTH-1:0];
      rd_front_q <= front_mem[fh_q];
      rd_back_q  <= back_mem[bh_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fwe) begin
      front_mem[fwaddr] <= fwdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && bwe) begin
      back_mem[bwaddr] <= bwdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      popped_q <= popped_d;
      status_q <= status_d;
      occ_q    <= occ_d;
    end
  end

  assign popped_o = popped_q;
  assign status_o = status_q;
  assign occ_o    = occ_q;

endmodule

// File: rtl/core/queue_with_middle_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_with_middle_insert
// Bounded queue with push at the tail, insert at the middle and pop at the
// head; every request returns one result with status and occupancy.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the operation (push,
//   insert at middle, pop) and tdata the value. Results leave on the m_axis
//   channel: tuser carries the status (done, pop on empty, push or insert on full) and
//   tdata the popped value and the occupancy after the operation.
//   A request is handled in a read step, which launches the reads of both
//   half stores at their heads, and then a write-back step, which writes back
//   and updates the pointers. The block takes no new request until the
//   current one is written back, as the reads of the half stores are registered.
//   The result is valid once the write-back edge has loaded the output register.
//   The result sits in an output register, so the next request is accepted
//   while it waits. If the receiver stalls, the following request holds in
//   its write-back cycle until the output register frees.
//   Reset empties the queue at once (heads and counts clear); the stores are
//   not cleared and need no sweep, so requests are taken right after reset.
// ----------------------------------------------------------------------------
module queue_with_middle_insert #(
  parameter int CAPACITY   = qmi_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = qmi_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] popped_value, [42:32] occupancy
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  qmi_pkg::ctrl_cmd_t                 cmd;
  logic [qmi_pkg::VALUE_W-1:0]        popped;
  logic [qmi_pkg::OCC_W-1:0]          occ;

  qmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  qmi_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .op_i     (s_axis_tuser_i),
    .value_i  (s_axis_tdata_i),
    .popped_o (popped),
    .status_o (m_axis_tuser_o),
    .occ_o    (occ)
  );

  assign m_axis_tdata_o = {5'b0, occ, popped};

endmodule

// File: rtl/core/qmi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmi_checker
// Port-level checks of the queue with middle insertion, bound to the top.
// ----------------------------------------------------------------------------
module qmi_checker #(
  parameter int CAPACITY = qmi_pkg::CAPACITY_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  localparam logic [qmi_pkg::OCC_W-1:0] CAP_OCC = qmi_pkg::OCC_W'(CAPACITY);

  // A result that is not taken stays.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // An accepted request is followed by a valid result at the output register.
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> ##2 m_axis_tvalid_o)
    else $error("no result after an accepted request");

  // A pop on an empty queue reports nothing stored and no value.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == qmi_pkg::STATUS_EMPTY
      |-> m_axis_tdata_o[31:0] == '0 && m_axis_tdata_o[42:32] == '0)
    else $error("empty status with nonzero data");

  // A push or insert refused as full reports a full queue.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == qmi_pkg::STATUS_FULL
      |-> m_axis_tdata_o[42:32] == CAP_OCC && m_axis_tdata_o[31:0] == '0)
    else $error("full status with wrong occupancy");

endmodule

bind queue_with_middle_insert qmi_checker #(.CAPACITY(CAPACITY)) u_qmi_checker (.*);
